### design/kpt_pkg.sv
package kpt_pkg;

    // Geometry
    localparam int AXES      = 3;
    localparam int COORD_W   = 32;
    localparam int COV_W     = 24;
    localparam int CNT_W     = 16;
    localparam int FRAC      = 16;
    localparam int K_W       = FRAC + 1;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((AXES * COORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((AXES * COORD_W + 2 * CNT_W + 7) / 8) * 8;

    // Gain divider
    localparam int DEN_W      = COV_W + 1;
    localparam int DIV_STEPS  = K_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int COV_PROD_W = K_W + COV_W;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PREDICT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CORRECT = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COV      = 2'd2;

    localparam logic [COV_W-1:0] PROCESS_NOISE_RST = 24'd655;
    localparam logic [COV_W-1:0] MEAS_NOISE_RST    = 24'd6554;
    localparam logic [COV_W-1:0] INIT_COV_RST      = 24'd65536;

    localparam logic [COV_W-1:0] COV_MAX = {COV_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef logic [COORD_W-1:0] coord_t;

endpackage

### design/kpt_gain_div.sv
module kpt_gain_div import kpt_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [COV_W-1:0] cov_pre,
    input  logic [COV_W-1:0] meas_noise,
    output logic             done,
    output logic [K_W-1:0]   gain
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [K_W-1:0]       num_reg;
    logic [K_W-1:0]       quo_reg;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 fits;

    // one restoring step per cycle; upper quotient bits are known zero
    assign trial = {rem_reg, num_reg[K_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            num_reg  <= '0;
            quo_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                den_reg  <= DEN_W'(cov_pre) + DEN_W'(meas_noise);
                rem_reg  <= DEN_W'(cov_pre[COV_W-1:1]);
                num_reg  <= {cov_pre[0], {FRAC{1'b0}}};
                quo_reg  <= '0;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_reg <= {quo_reg[K_W-2:0], fits};
                num_reg <= {num_reg[K_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // zero denominator gives zero gain
    assign gain = (den_reg == '0) ? '0 : quo_reg;
    assign done = done_reg;

endmodule

### design/kpt_lane.sv
module kpt_lane import kpt_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  coord_t         pre,
    input  coord_t         meas,
    input  logic [K_W-1:0] gain,
    output logic           done,
    output coord_t         post
);

    localparam int HI_W      = COORD_W + 1 - FRAC;
    localparam int PROD_HI_W = HI_W + K_W;
    localparam int PROD_LO_W = FRAC + K_W;
    localparam int DM_W      = PROD_HI_W + 1;
    localparam logic [PROD_LO_W:0] ROUND_HALF = (PROD_LO_W + 1)'(1) << (FRAC - 1);

    logic [COORD_W:0] diff;
    logic [COORD_W:0] mag;
    logic             neg;

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 neg1_reg, neg2_reg;
    coord_t               pre1_reg, pre2_reg;
    logic [HI_W-1:0]      hi1_reg;
    logic [FRAC-1:0]      lo1_reg;
    logic [K_W-1:0]       gain1_reg;
    logic [PROD_HI_W-1:0] prod_hi2_reg;
    logic [PROD_LO_W-1:0] prod_lo2_reg;
    coord_t               post_reg;

    logic [PROD_LO_W:0] lo_rnd;
    logic [DM_W-1:0]    dm;
    coord_t             post_next;

    assign diff = {meas[COORD_W-1], meas} - {pre[COORD_W-1], pre};
    assign neg  = diff[COORD_W];
    assign mag  = neg ? (~diff + 1'b1) : diff;

    assign lo_rnd    = {1'b0, prod_lo2_reg} + ROUND_HALF;
    assign dm        = DM_W'(prod_hi2_reg) + DM_W'(lo_rnd[PROD_LO_W:FRAC]);
    // the step never passes the measurement, so wraparound at COORD_W is exact
    assign post_next = neg2_reg ? (pre2_reg - dm[COORD_W-1:0])
                                : (pre2_reg + dm[COORD_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg1_reg  <= neg;
            pre1_reg  <= pre;
            hi1_reg   <= mag[COORD_W:FRAC];
            lo1_reg   <= mag[FRAC-1:0];
            gain1_reg <= gain;
        end
        if (v1_reg) begin
            neg2_reg     <= neg1_reg;
            pre2_reg     <= pre1_reg;
            prod_hi2_reg <= PROD_HI_W'(hi1_reg) * PROD_HI_W'(gain1_reg);
            prod_lo2_reg <= PROD_LO_W'(lo1_reg) * PROD_LO_W'(gain1_reg);
        end
        if (v2_reg) begin
            post_reg <= post_next;
        end
    end

    assign done = v3_reg;
    assign post = post_reg;

endmodule

### design/kalman_point_tracker_3d.sv
// Channel   | Ports                  | Payload (low bit first)
// ----------+------------------------+----------------------------------------------
// input     | s_tvalid/s_tready      | s_tdata: point_x, point_y, point_z; s_tuser: kind
// result    | m_tvalid/m_tready      | m_tdata: est_x, est_y, est_z, frames_since_update,
//           |                        |         track_age
// config    | cfg_we/cfg_index       | cfg_wdata: 24-bit register value
//
// Start, predict and unused kinds: the request moves to S_EMIT, which registers the result.
// Correct: the result waits for the 17-step gain divider and the 3-stage axis lanes.
// One request is in flight at a time; the next is taken while the result still waits.
// A stalled m_tready holds the result register and stops completion of the next request.
// aresetn is synchronous, active low, clears the filter state and loads the config reset values.
module kalman_point_tracker_3d import kpt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // point_x, point_y, point_z
    input  logic [KIND_W-1:0]    s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // est_x, est_y, est_z, frames_since_update,
                                            // track_age
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COV_W-1:0]     cfg_wdata
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_LANE, S_EMIT} state_t;

    localparam logic [COV_PROD_W:0] COV_ROUND = (COV_PROD_W + 1)'(1) << (FRAC - 1);

    state_t state_reg;

    logic [COV_W-1:0] q_reg, r_reg, p0_reg;
    coord_t           post_reg [AXES];
    coord_t           pre_reg  [AXES];
    coord_t           meas_reg [AXES];
    logic [COV_W-1:0] cov_post_reg, cov_pre_reg;
    logic [CNT_W-1:0] since_reg, age_reg;
    logic [COV_PROD_W-1:0] cov_prod_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    logic             in_take;
    logic             out_free;
    logic             div_start;
    logic             div_done;
    logic [K_W-1:0]   div_gain;
    logic             lane_start;
    logic [AXES-1:0]  lane_done;
    coord_t           lane_post [AXES];
    logic [COV_W:0]   cov_sum;
    logic [COV_W-1:0] cov_pred;
    logic [COV_PROD_W:0] cov_rnd;
    logic [COV_W-1:0] cov_corr;

    assign s_tready   = (state_reg == S_IDLE);
    assign in_take    = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign div_start  = in_take && (s_tuser == KIND_CORRECT);
    assign lane_start = (state_reg == S_DIV) && div_done;

    assign cov_sum  = {1'b0, cov_post_reg} + {1'b0, q_reg};
    assign cov_pred = cov_sum[COV_W] ? COV_MAX : cov_sum[COV_W-1:0];
    assign cov_rnd  = {1'b0, cov_prod_reg} + COV_ROUND;
    assign cov_corr = cov_pre_reg - cov_rnd[FRAC+COV_W-1:FRAC];

    kpt_gain_div u_gain_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .cov_pre    (cov_pre_reg),
        .meas_noise (r_reg),
        .done       (div_done),
        .gain       (div_gain)
    );

    for (genvar i = 0; i < AXES; i++) begin : g_lane
        kpt_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (lane_start),
            .pre     (pre_reg[i]),
            .meas    (meas_reg[i]),
            .gain    (div_gain),
            .done    (lane_done[i]),
            .post    (lane_post[i])
        );
    end

    // merge the axis estimates and the shared counters into one result word
    always_comb begin
        m_tdata_next = '0;
        for (int i = 0; i < AXES; i++) begin
            m_tdata_next[i*COORD_W +: COORD_W] = post_reg[i];
        end
        m_tdata_next[AXES*COORD_W +: CNT_W]         = since_reg;
        m_tdata_next[AXES*COORD_W + CNT_W +: CNT_W] = age_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg  <= PROCESS_NOISE_RST;
            r_reg  <= MEAS_NOISE_RST;
            p0_reg <= INIT_COV_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PROCESS_NOISE: q_reg  <= cfg_wdata;
                CFG_MEAS_NOISE:    r_reg  <= cfg_wdata;
                CFG_INIT_COV:      p0_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            for (int i = 0; i < AXES; i++) begin
                meas_reg[i] <= s_tdata[i*COORD_W +: COORD_W];
            end
        end
        if (lane_start) begin
            cov_prod_reg <= COV_PROD_W'(div_gain) * COV_PROD_W'(cov_pre_reg);
        end
        if (state_reg == S_EMIT && out_free) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            cov_post_reg <= '0;
            cov_pre_reg  <= '0;
            since_reg    <= '0;
            age_reg      <= '0;
            for (int i = 0; i < AXES; i++) begin
                post_reg[i] <= '0;
                pre_reg[i]  <= '0;
            end
        end else begin
            // drop the taken result unless a new one is loaded in its place
            if (m_tvalid_reg && m_tready && state_reg != S_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_take) begin
                        state_reg <= S_EMIT;
                        case (s_tuser)
                            KIND_START: begin
                                for (int i = 0; i < AXES; i++) begin
                                    post_reg[i] <= s_tdata[i*COORD_W +: COORD_W];
                                    pre_reg[i]  <= '0;
                                end
                                cov_post_reg <= p0_reg;
                                cov_pre_reg  <= '0;
                                since_reg    <= '0;
                                age_reg      <= '0;
                            end
                            KIND_PREDICT: begin
                                // prior equals posterior, so the posterior is what goes out
                                for (int i = 0; i < AXES; i++) begin
                                    pre_reg[i] <= post_reg[i];
                                end
                                cov_pre_reg  <= cov_pred;
                                cov_post_reg <= cov_pred;
                                if (since_reg != CNT_MAX) since_reg <= since_reg + 1'b1;
                                if (age_reg != CNT_MAX) age_reg <= age_reg + 1'b1;
                            end
                            KIND_CORRECT: begin
                                state_reg <= S_DIV;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_LANE;
                    end
                end
                S_LANE: begin
                    if (&lane_done) begin
                        for (int i = 0; i < AXES; i++) begin
                            post_reg[i] <= lane_post[i];
                        end
                        cov_post_reg <= cov_corr;
                        since_reg    <= '0;
                        state_reg    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // hold until the result register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
